// ===== src/csc_pkg.sv =====
`default_nettype none

package csc_pkg;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_HOLD_MS       = 2'd0;
   localparam logic [1:0] CSR_STABLE_MS     = 2'd1;
   localparam logic [1:0] CSR_ALT_WINDOW_MS = 2'd2;
   localparam logic [1:0] CSR_DETECT_LEVEL  = 2'd3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   // Reset values of the configuration registers.
   localparam logic [15:0] HOLD_MS_RESET       = 16'd3000;
   localparam logic [15:0] STABLE_MS_RESET     = 16'd400;
   localparam logic [15:0] ALT_WINDOW_MS_RESET = 16'd1500;
   localparam logic        DETECT_LEVEL_RESET  = 1'b0;

   // Charger state codes.
   localparam logic [1:0] ST_NO_POWER   = 2'd0;
   localparam logic [1:0] ST_NO_BATTERY = 2'd1;
   localparam logic [1:0] ST_CHARGING   = 2'd2;
   localparam logic [1:0] ST_FULL       = 2'd3;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        detect_level;
      logic        full_level;
   } req_type;

   typedef struct packed {
      logic [1:0] charge_state;
      logic       power_ok;
      logic       charging;
      logic       full_res;
      logic       battery_absent;
      logic       changed;
   } rsp_type;

   typedef struct packed {
      logic [15:0] hold_ms;
      logic [15:0] stable_ms;
      logic [15:0] alt_window_ms;
      logic        detect_active_level;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/csc_csr.sv =====
`default_nettype none

module csc_csr
   import csc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HOLD_MS:       cfg_in.hold_ms             = csr_wdata;
            CSR_STABLE_MS:     cfg_in.stable_ms           = csr_wdata;
            CSR_ALT_WINDOW_MS: cfg_in.alt_window_ms       = csr_wdata;
            CSR_DETECT_LEVEL:  cfg_in.detect_active_level = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ms             <= HOLD_MS_RESET;
         cfg_ff.stable_ms           <= STABLE_MS_RESET;
         cfg_ff.alt_window_ms       <= ALT_WINDOW_MS_RESET;
         cfg_ff.detect_active_level <= DETECT_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/csc_core.sv =====
`default_nettype none

module csc_core
   import csc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   logic [31:0] last_power_time_ff, last_power_time_in;
   logic        power_seen_valid_ff, power_seen_valid_in;
   logic [31:0] last_detect_time_ff, last_detect_time_in;
   logic        detect_seen_valid_ff, detect_seen_valid_in;
   logic [31:0] last_full_time_ff, last_full_time_in;
   logic        full_seen_valid_ff, full_seen_valid_in;
   logic [31:0] detect_run_start_ff, detect_run_start_in;
   logic        detect_run_valid_ff, detect_run_valid_in;
   logic [31:0] full_run_start_ff, full_run_start_in;
   logic        full_run_valid_ff, full_run_valid_in;
   logic [5:0]  snapshot_ff, snapshot_in;

   logic        det;
   logic        full;
   logic        power;
   logic        det_stable;
   logic        full_steady;
   logic        alt;
   logic        nobat;
   logic [1:0]  state;
   logic        charging;
   logic        full_flag;

   assign det  = (item.detect_level == cfg.detect_active_level);
   assign full = item.full_level;

   // State as it stands after this poll has been folded in.
   always_comb begin
      last_power_time_in   = last_power_time_ff;
      power_seen_valid_in  = power_seen_valid_ff;
      last_detect_time_in  = last_detect_time_ff;
      detect_seen_valid_in = detect_seen_valid_ff;
      last_full_time_in    = last_full_time_ff;
      full_seen_valid_in   = full_seen_valid_ff;
      detect_run_start_in  = detect_run_start_ff;
      detect_run_valid_in  = detect_run_valid_ff;
      full_run_start_in    = full_run_start_ff;
      full_run_valid_in    = full_run_valid_ff;

      if (det) begin
         last_power_time_in   = item.now_ms;
         power_seen_valid_in  = 1'b1;
         last_detect_time_in  = item.now_ms;
         detect_seen_valid_in = 1'b1;
         if (!detect_run_valid_ff) begin
            detect_run_start_in = item.now_ms;
            detect_run_valid_in = 1'b1;
         end
      end else begin
         detect_run_valid_in = 1'b0;
         detect_run_start_in = '0;
      end

      if (full) begin
         last_power_time_in = item.now_ms;
         power_seen_valid_in = 1'b1;
         last_full_time_in   = item.now_ms;
         full_seen_valid_in  = 1'b1;
         if (!full_run_valid_ff) begin
            full_run_start_in = item.now_ms;
            full_run_valid_in = 1'b1;
         end
      end else begin
         full_run_valid_in = 1'b0;
         full_run_start_in = '0;
      end
   end

   // Elapsed times wrap modulo 2^32, so a plain 32-bit subtraction serves.
   assign power = power_seen_valid_in &&
      ((item.now_ms - last_power_time_in) <= {16'd0, cfg.hold_ms});
   assign det_stable = detect_run_valid_in &&
      ((item.now_ms - detect_run_start_in) >= {16'd0, cfg.stable_ms});
   assign full_steady = full_run_valid_in &&
      ((item.now_ms - full_run_start_in) >= {16'd0, cfg.stable_ms});
   assign alt = power && detect_seen_valid_in && full_seen_valid_in &&
      ((item.now_ms - last_detect_time_in) <= {16'd0, cfg.alt_window_ms}) &&
      ((item.now_ms - last_full_time_in) <= {16'd0, cfg.alt_window_ms});
   assign nobat = alt && !det_stable && !full_steady;

   always_comb begin
      if (!power) begin
         state = ST_NO_POWER;
      end else if (nobat) begin
         state = ST_NO_BATTERY;
      end else if (det_stable) begin
         state = ST_CHARGING;
      end else if (full_steady) begin
         state = ST_FULL;
      end else begin
         state = ST_CHARGING;
      end
   end

   assign charging    = (state == ST_CHARGING) || (state == ST_NO_BATTERY);
   assign full_flag   = (state == ST_FULL);
   assign snapshot_in = {nobat, full_flag, charging, power, state};

   assign result = {state, power, charging, full_flag, nobat, (snapshot_in != snapshot_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         last_power_time_ff   <= '0;
         power_seen_valid_ff  <= 1'b0;
         last_detect_time_ff  <= '0;
         detect_seen_valid_ff <= 1'b0;
         last_full_time_ff    <= '0;
         full_seen_valid_ff   <= 1'b0;
         detect_run_start_ff  <= '0;
         detect_run_valid_ff  <= 1'b0;
         full_run_start_ff    <= '0;
         full_run_valid_ff    <= 1'b0;
         snapshot_ff          <= '0;
      end else if (advance) begin
         last_power_time_ff   <= last_power_time_in;
         power_seen_valid_ff  <= power_seen_valid_in;
         last_detect_time_ff  <= last_detect_time_in;
         detect_seen_valid_ff <= detect_seen_valid_in;
         last_full_time_ff    <= last_full_time_in;
         full_seen_valid_ff   <= full_seen_valid_in;
         detect_run_start_ff  <= detect_run_start_in;
         detect_run_valid_ff  <= detect_run_valid_in;
         full_run_start_ff    <= full_run_start_in;
         full_run_valid_ff    <= full_run_valid_in;
         snapshot_ff          <= snapshot_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/charge_status_classifier.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// req_      in         req_valid / req_ready      req_payload (poll time, pin levels)
// rsp_      out        rsp_valid / rsp_ready      rsp_payload (state, flags, changed)
// csr_      in         csr_we, no wait            csr_index, csr_wdata
//
// A poll transaction is captured in an input register, classified there and
// written to the result register; one transaction is taken every cycle while
// the result register is not stalled. Reset is synchronous and active high and
// clears all history and the stored snapshot. When the result register is full
// and not taken, the input register holds and req_ready drops; nothing is lost.

module charge_status_classifier
   import csc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_payload,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_payload,

   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   rsp_type result;
   logic    advance;
   logic    accept;

   // The classification step moves forward whenever the result register is
   // empty or is being emptied in this very cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   csc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The core updates its pin history only on the cycle the transaction
   // moves into the result register, so stalls never double-count a poll.
   csc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import csc_pkg::*;

   // Pin behavior of one random charger session.
   typedef enum int {
      PAT_CHARGING,
      PAT_FULL,
      PAT_ALTERNATING,
      PAT_UNPLUGGED,
      PAT_ERRATIC
   } pin_pattern_e;

   // Shape of a random register setting.
   typedef enum int {
      PROF_TYPICAL,
      PROF_TINY,
      PROF_WIDE,
      PROF_EXTREME
   } cfg_profile_e;

   localparam int SESSION_POLLS = 1650;
   localparam int NOISE_POLLS   = 220;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   charge_status_classifier dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #2 clock = ~clock;

   // Shadow copy of the configuration registers.
   logic [15:0] cfg_hold   = HOLD_MS_RESET;
   logic [15:0] cfg_stable = STABLE_MS_RESET;
   logic [15:0] cfg_window = ALT_WINDOW_MS_RESET;
   logic        cfg_level  = DETECT_LEVEL_RESET;

   // Charger history as the DUT should hold it. All of it is zero after reset.
   logic [31:0] power_seen_ms  = '0;
   logic        power_seen     = 1'b0;
   logic [31:0] detect_seen_ms = '0;
   logic        detect_seen    = 1'b0;
   logic [31:0] full_seen_ms   = '0;
   logic        full_seen      = 1'b0;
   logic [31:0] detect_run_ms  = '0;
   logic        detect_running = 1'b0;
   logic [31:0] full_run_ms    = '0;
   logic        full_running   = 1'b0;
   // Last reported snapshot without the changed bit: state in the low two
   // bits, then power, charging, full and the no-battery flag. The reset
   // value, all zero, is the no-power snapshot with every flag low.
   logic [5:0]  last_snapshot  = '0;

   rsp_type     expected_snapshots[$];
   rsp_type     oldest;
   int          fail_count = 0;

   // Idling controls. When a flag is low, that side never idles.
   bit          gaps_on   = 1'b0;
   bit          stalls_on = 1'b0;
   int          stall_left = 0;

   // Timeline of the random sessions and the largest step between polls.
   logic [31:0] poll_ms  = '0;
   int unsigned step_max = 20;

   // Elapsed milliseconds, modulo 2^32, read as unsigned.
   function automatic logic [31:0] ms_since(logic [31:0] now_ms, logic [31:0] earlier);
      return now_ms - earlier;
   endfunction

   // Updates the charger history with one poll and returns the snapshot that
   // the DUT has to report for it.
   function automatic rsp_type classify_poll(req_type poll);
      logic       det_on;
      logic       power;
      logic       det_stable;
      logic       full_steady;
      logic       alternating;
      logic       nobat;
      logic [5:0] snapshot;
      rsp_type    result;

      det_on = (poll.detect_level == cfg_level);

      if (det_on) begin
         power_seen_ms  = poll.now_ms;
         power_seen     = 1'b1;
         detect_seen_ms = poll.now_ms;
         detect_seen    = 1'b1;
         if (!detect_running) begin
            detect_run_ms  = poll.now_ms;
            detect_running = 1'b1;
         end
      end else begin
         detect_running = 1'b0;
         detect_run_ms  = '0;
      end

      if (poll.full_level) begin
         power_seen_ms = poll.now_ms;
         power_seen    = 1'b1;
         full_seen_ms  = poll.now_ms;
         full_seen     = 1'b1;
         if (!full_running) begin
            full_run_ms  = poll.now_ms;
            full_running = 1'b1;
         end
      end else begin
         full_running = 1'b0;
         full_run_ms  = '0;
      end

      power       = power_seen && ms_since(poll.now_ms, power_seen_ms) <= {16'd0, cfg_hold};
      det_stable  = detect_running &&
                    ms_since(poll.now_ms, detect_run_ms) >= {16'd0, cfg_stable};
      full_steady = full_running &&
                    ms_since(poll.now_ms, full_run_ms) >= {16'd0, cfg_stable};
      alternating = power && detect_seen && full_seen &&
                    ms_since(poll.now_ms, detect_seen_ms) <= {16'd0, cfg_window} &&
                    ms_since(poll.now_ms, full_seen_ms) <= {16'd0, cfg_window};
      nobat       = alternating && !det_stable && !full_steady;

      // No power wins over everything, then the no-battery pattern; a stable
      // detect pin wins over a stable full pin; with neither pin stable the
      // charger is taken as charging.
      if (!power) begin
         result.charge_state = ST_NO_POWER;
      end else if (nobat) begin
         result.charge_state = ST_NO_BATTERY;
      end else if (det_stable) begin
         result.charge_state = ST_CHARGING;
      end else if (full_steady) begin
         result.charge_state = ST_FULL;
      end else begin
         result.charge_state = ST_CHARGING;
      end

      result.power_ok       = power;
      result.charging       = (result.charge_state == ST_CHARGING) ||
                              (result.charge_state == ST_NO_BATTERY);
      result.full_res       = (result.charge_state == ST_FULL);
      result.battery_absent = nobat;

      snapshot       = {nobat, result.full_res, result.charging, result.power_ok,
                        result.charge_state};
      result.changed = (snapshot != last_snapshot);
      last_snapshot  = snapshot;
      return result;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(12, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [31:0] next_step();
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(0, 4 * step_max + 8);
      end
      return $urandom_range(0, step_max);
   endfunction

   // Sends one poll. Payload and valid change only at the falling edge, and
   // the prediction is made at the rising edge that accepts the transaction.
   task automatic send_poll(input logic [31:0] now_ms, input logic detect_level,
                            input logic full_level);
      req_type item;
      int      gap;

      item.now_ms       = now_ms;
      item.detect_level = detect_level;
      item.full_level   = full_level;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      expected_snapshots.push_back(classify_poll(item));

      gap = 0;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stops sending and waits until every predicted snapshot has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_snapshots.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_HOLD_MS:       cfg_hold   = value;
         CSR_STABLE_MS:     cfg_stable = value;
         CSR_ALT_WINDOW_MS: cfg_window = value;
         CSR_DETECT_LEVEL:  cfg_level  = value[0];
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [15:0] hold, input logic [15:0] stable,
                               input logic [15:0] window, input logic level);
      write_reg(CSR_HOLD_MS, hold);
      write_reg(CSR_STABLE_MS, stable);
      write_reg(CSR_ALT_WINDOW_MS, window);
      write_reg(CSR_DETECT_LEVEL, {15'd0, level});
   endtask

   // Picks a register setting and the step size that suits it: tiny values
   // with tiny steps cross every threshold often, typical values follow a
   // real charger, and the extremes pin each register at zero or full scale.
   task automatic randomize_config();
      cfg_profile_e profile;
      logic [15:0]  hold;
      logic [15:0]  stable;
      logic [15:0]  window;

      profile = cfg_profile_e'($urandom_range(0, 3));
      case (profile)
         PROF_TYPICAL: begin
            hold     = 16'($urandom_range(2000, 4000));
            stable   = 16'($urandom_range(200, 800));
            window   = 16'($urandom_range(1000, 2000));
            step_max = 2000;
         end
         PROF_TINY: begin
            hold     = 16'($urandom_range(0, 20));
            stable   = 16'($urandom_range(0, 20));
            window   = 16'($urandom_range(0, 20));
            step_max = 12;
         end
         PROF_WIDE: begin
            hold     = 16'($urandom_range(0, 65535));
            stable   = 16'($urandom_range(0, 65535));
            window   = 16'($urandom_range(0, 65535));
            step_max = $urandom_range(1000, 40000);
         end
         default: begin
            hold     = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            stable   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            window   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            step_max = $urandom_range(0, 1) ? 3 : 70000;
         end
      endcase
      write_config(hold, stable, window, 1'($urandom_range(0, 1)));
   endtask

   // One plugged-in or unplugged stretch of a charger. The pattern can
   // switch in the middle, as when a cable is pulled or a battery inserted,
   // and single polls can glitch.
   task automatic run_session(output int count);
      pin_pattern_e pattern;
      int           len;
      logic         det_on;
      logic         full_on;
      logic         alt_phase;

      pattern   = pin_pattern_e'($urandom_range(0, 4));
      len       = $urandom_range(4, 40);
      alt_phase = 1'($urandom_range(0, 1));

      // Start most sessions where the last one ended; some start anywhere,
      // some just before the timestamp wraps.
      case ($urandom_range(0, 9))
         0:       poll_ms = $urandom;
         1:       poll_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
         default: ;
      endcase

      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            pattern = pin_pattern_e'($urandom_range(0, 4));
         end
         poll_ms = poll_ms + next_step();
         case (pattern)
            PAT_CHARGING: begin
               det_on  = 1'b1;
               full_on = 1'b0;
            end
            PAT_FULL: begin
               det_on  = 1'b0;
               full_on = 1'b1;
            end
            PAT_ALTERNATING: begin
               det_on    = alt_phase;
               full_on   = ~alt_phase;
               alt_phase = ~alt_phase;
            end
            PAT_UNPLUGGED: begin
               det_on  = 1'b0;
               full_on = 1'b0;
            end
            default: begin
               det_on  = 1'($urandom_range(0, 1));
               full_on = 1'($urandom_range(0, 1));
            end
         endcase
         if ($urandom_range(0, 19) == 0) begin
            det_on = ~det_on;
         end
         if ($urandom_range(0, 19) == 0) begin
            full_on = ~full_on;
         end
         send_poll(poll_ms, det_on ? cfg_level : ~cfg_level, full_on);
      end
      count = len;
   endtask

   // Directed polls at the reset configuration: hold 3000, stable 400,
   // window 1500, detect pin active low.
   task automatic test_reset_config();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_poll(32'd0, 1'b1, 1'b0);            // nothing seen yet: no power
      send_poll(32'd100, 1'b0, 1'b0);          // detect run starts, not yet stable
      send_poll(32'd600, 1'b0, 1'b0);          // detect stable: charging
      send_poll(32'd700, 1'b1, 1'b1);          // both pins inside the window
      send_poll(32'd1200, 1'b1, 1'b1);         // full pin stable: full
      send_poll(32'd1300, 1'b0, 1'b1);         // full still wins, detect run fresh
      send_poll(32'd1800, 1'b0, 1'b1);         // both stable: charging has priority
      send_poll(32'd5000, 1'b1, 1'b0);         // past the hold time: no power
      send_poll(32'hFFFF_FF00, 1'b0, 1'b0);
      send_poll(32'h0000_0100, 1'b0, 1'b0);    // run spans the timestamp wrap
      send_poll(32'h0000_0050, 1'b0, 1'b0);    // time runs backwards
      send_poll(32'h0000_0040, 1'b1, 1'b0);    // backwards again: stale history
      send_poll(32'hFFFF_FFFF, 1'b1, 1'b1);
   endtask

   // Each register at zero, then at full scale, with the detect pin
   // active high. Polls land on and one millisecond past each threshold.
   task automatic test_register_extremes();
      write_config(16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_poll(32'd10, 1'b1, 1'b0);           // zero stable time: stable at once
      send_poll(32'd10, 1'b0, 1'b1);           // same ms counts within a zero window
      send_poll(32'd11, 1'b0, 1'b0);           // one ms later: no power
      send_poll(32'd11, 1'b1, 1'b1);

      write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_poll(32'd65546, 1'b0, 1'b0);        // exactly the hold time: powered
      send_poll(32'd65547, 1'b1, 1'b1);
      send_poll(32'd131081, 1'b1, 1'b1);       // one ms short of stable: no battery
      send_poll(32'd131082, 1'b1, 1'b1);       // stable now: charging
      send_poll(32'd262000, 1'b0, 1'b0);
   endtask

   // The sender stops in the middle of traffic until all results are back,
   // then carries on with the same history.
   task automatic test_drain_mid_stream();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      step_max  = 2000;
      write_config(HOLD_MS_RESET, STABLE_MS_RESET, ALT_WINDOW_MS_RESET, DETECT_LEVEL_RESET);
      for (int i = 0; i < 30; i++) begin
         poll_ms = poll_ms + next_step();
         send_poll(poll_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      wait_idle();
      for (int i = 0; i < 30; i++) begin
         poll_ms = poll_ms + next_step();
         send_poll(poll_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Random charger sessions. Every few sessions the registers change and
   // idling on each side is switched on or off, so some phases run back to
   // back with no gaps or stalls at all.
   task automatic test_charger_sessions();
      int sent;
      int count;

      sent = 0;
      while (sent < SESSION_POLLS) begin
         randomize_config();
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 5)) begin
            run_session(count);
            sent += count;
         end
      end
   endtask

   // Unrestricted timestamps and pins: every timestamp bit takes both values.
   task automatic test_noise_polls();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      for (int i = 0; i < NOISE_POLLS; i++) begin
         if (i % 80 == 0) begin
            randomize_config();
         end
         send_poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Receiver side: ready is lowered for random stretches while stalls are
   // on; it changes only at the falling edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
      end
   end

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // Each result transaction is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_snapshots.size() == 0) begin
            $error("result transaction with no poll waiting for it");
            fail_count++;
         end else begin
            oldest = expected_snapshots.pop_front();
            check_field("charge_state", 32'(oldest.charge_state),
                        32'(rsp_payload.charge_state));
            check_field("power_ok", 32'(oldest.power_ok), 32'(rsp_payload.power_ok));
            check_field("charging", 32'(oldest.charging), 32'(rsp_payload.charging));
            check_field("full_res", 32'(oldest.full_res), 32'(rsp_payload.full_res));
            check_field("battery_absent", 32'(oldest.battery_absent),
                        32'(rsp_payload.battery_absent));
            check_field("changed", 32'(oldest.changed), 32'(rsp_payload.changed));
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_config();
      test_register_extremes();
      test_drain_mid_stream();
      test_charger_sessions();
      test_noise_polls();

      // Drain the last snapshots, then leave room for a stray extra result.
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("charge_status_classifier verification clean");
      end else begin
         $display("charge_status_classifier verification failed");
      end
      $finish;
   end

   // Generous bound on the whole run; reaching it means the DUT hung.
   initial begin
      #5_000_000;
      $display("charge_status_classifier verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/csc_pkg.sv
src/csc_csr.sv
src/csc_core.sv
src/charge_status_classifier.sv
tb/tb.sv
